// ===== src/radial_order_index_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Radial order index generator assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RADIAL_ORDER_INDEX_GENERATOR_ASSERT_SVH
`define RADIAL_ORDER_INDEX_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RIO_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radial order index generator check failed");

// Consequent must hold in the cycle after the antecedent.
`define RIO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radial order index generator check failed");

`endif

// ===== src/rio_pkg.sv =====
// ----------------------------------------------------------------------------
// Radial order index generator package
// Field widths, register indexes, reset values and channel payload types.
// ----------------------------------------------------------------------------
package rio_pkg;

    // Fixed field widths
    localparam int CELL_W     = 12;
    localparam int RAD_W      = 13;
    localparam int LEN_W      = 7;
    localparam int KEEP_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Smallest legal grid
    localparam int MIN_WIDTH  = 2;
    localparam int MIN_HEIGHT = 1;

    // Register reset values
    localparam logic [LEN_W-1:0]  ROW_LENGTH_RST = 7'd64;
    localparam logic [LEN_W-1:0]  ROW_COUNT_RST  = 7'd64;
    localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = 13'd4096;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH = 2'd0,
        REG_ROW_COUNT  = 2'd1,
        REG_KEEP_COUNT = 2'd2
    } t_reg_idx;

    // Request payload
    typedef struct packed {
        logic restart;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [CELL_W-1:0] cell_index;
        logic [RAD_W-1:0]  radius_squared;
        logic              valid_res;
        logic              last;
    } t_res;

    // Configuration write payload
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

endpackage

// ===== src/rio_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one next-entry or restart request.
// ----------------------------------------------------------------------------
interface rio_req_if;
    logic          valid;
    logic          ready;
    rio_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rio_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one ordered grid entry.
// ----------------------------------------------------------------------------
interface rio_res_if;
    logic          valid;
    logic          ready;
    rio_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rio_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rio_cfg_if;
    logic          valid;
    logic          ready;
    rio_pkg::t_cfg data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/radial_order_index_generator.sv =====
// ----------------------------------------------------------------------------
// Radial order index generator
// Lists the cells of a frequency grid by rising squared radius, ties broken
// by ascending row-major index, one cell per request.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transfer payload
//  -------  ---  -------------------------------------------------------
//  i_cfg    in   index (row_length, row_count, keep_count), data
//  i_req    in   restart
//  o_res    out  cell_index, radius_squared, valid_res, last
//
//  A request scans the clamped grid, one cell per cycle through a single
//  squared-radius and key-compare unit: each cell passes the squared-radius
//  stage, the scan then ends in the put state, which registers the result,
//  and the next request is taken after that. A request in an ended run skips
//  the scan and goes straight to the put state. The result sits in an output
//  register; the next request is taken while it waits, and a finished scan
//  holds until the register is free. Reset is synchronous, active low;
//  configuration writes are always taken.
//
module radial_order_index_generator #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rio_cfg_if.sink  i_cfg,
    rio_req_if.sink  i_req,
    rio_res_if.source o_res
);

    `include "radial_order_index_generator_assert.svh"

    // Derived widths
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int DXMAX   = MAX_WIDTH - MAX_WIDTH / 2;
    localparam int DW      = $clog2(DXMAX + 1);
    localparam int IW_RAW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int IW      = (IW_RAW > rio_pkg::CELL_W) ? IW_RAW : rio_pkg::CELL_W;
    localparam int R2_MAX  = DXMAX * DXMAX + (MAX_HEIGHT - 1) * (MAX_HEIGHT - 1);
    localparam int R2W_RAW = $clog2(R2_MAX + 1);
    localparam int R2W     = (R2W_RAW > rio_pkg::RAD_W) ? R2W_RAW : rio_pkg::RAD_W;
    localparam int KW      = rio_pkg::KEEP_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PUT  = 3'b100
    } t_state;

    // Configuration registers
    logic [rio_pkg::LEN_W-1:0] r_row_length;
    logic [rio_pkg::LEN_W-1:0] r_row_count;
    logic [KW-1:0]             r_keep;

    // Run state
    logic [R2W-1:0] r_prev_r;
    logic [IW-1:0]  r_prev_i;
    logic [KW-1:0]  r_emitted;

    // Sequencer and scan counters
    t_state         r_state;
    t_state         n_state;
    logic           r_issue;
    logic           r_fresh;
    logic [WW-1:0]  r_col;
    logic [HW-1:0]  r_row;
    logic [IW-1:0]  r_idx;
    logic [R2W-1:0] r_rowsq;

    // Squared-radius stage
    logic           r_b_vld;
    logic [R2W-1:0] r_b_r2;
    logic [IW-1:0]  r_b_idx;

    // Running best key
    logic           r_found;
    logic [1:0]     r_cnt;
    logic [R2W-1:0] r_best_r;
    logic [IW-1:0]  r_best_i;

    // Output register
    logic          r_out_vld;
    rio_pkg::t_res r_out;

    // Combinational helpers
    logic [WW-1:0]   w_eff;
    logic [WW-1:0]   half;
    logic [HW-1:0]   h_eff;
    logic [WW-1:0]   dx_full;
    logic [DW-1:0]   dx;
    logic [2*DW-1:0] dx_sq;
    logic            last_cell;
    logic            req_fire;
    logic [KW-1:0]   emit_start;
    logic            gt_prev;
    logic            lt_best;
    logic            out_free;
    logic [KW:0]     emit_inc;
    logic            scan_done;

    // Clamp grid geometry
    always_comb begin
        if (int'(r_row_length) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else if (int'(r_row_length) < rio_pkg::MIN_WIDTH) begin
            w_eff = WW'(rio_pkg::MIN_WIDTH);
        end else begin
            w_eff = WW'(r_row_length);
        end
        if (int'(r_row_count) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else if (int'(r_row_count) < rio_pkg::MIN_HEIGHT) begin
            h_eff = HW'(rio_pkg::MIN_HEIGHT);
        end else begin
            h_eff = HW'(r_row_count);
        end
    end

    assign half = w_eff >> 1;

    // Wrapped column distance of the current cell
    assign dx_full   = (r_col >= half) ? (w_eff - r_col) : r_col;
    assign dx        = dx_full[DW-1:0];
    assign dx_sq     = dx * dx;
    assign last_cell = (r_col == w_eff - WW'(1)) && (r_row == h_eff - HW'(1));

    assign req_fire   = i_req.valid && i_req.ready;
    assign emit_start = i_req.data.restart ? '0 : r_emitted;
    assign scan_done  = !r_issue && !r_b_vld;
    assign out_free   = !r_out_vld || o_res.ready;
    assign emit_inc   = {1'b0, r_emitted} + (KW + 1)'(1);

    // Key compares against last returned key and running best
    assign gt_prev = r_fresh || (r_b_r2 > r_prev_r)
                   || ((r_b_r2 == r_prev_r) && (r_b_idx > r_prev_i));
    assign lt_best = !r_found || (r_b_r2 < r_best_r)
                   || ((r_b_r2 == r_best_r) && (r_b_idx < r_best_i));

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = (emit_start >= r_keep) ? S_PUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= rio_pkg::ROW_LENGTH_RST;
            r_row_count  <= rio_pkg::ROW_COUNT_RST;
            r_keep       <= rio_pkg::KEEP_COUNT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.data.index)
                rio_pkg::REG_ROW_LENGTH: r_row_length <= i_cfg.data.data[rio_pkg::LEN_W-1:0];
                rio_pkg::REG_ROW_COUNT:  r_row_count  <= i_cfg.data.data[rio_pkg::LEN_W-1:0];
                rio_pkg::REG_KEEP_COUNT: r_keep       <= i_cfg.data.data[KW-1:0];
                default: ;
            endcase
        end
    end

    // Control: state, issue flag, stage valid, found flag, run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_found   <= 1'b0;
            r_cnt     <= 2'd0;
            r_fresh   <= 1'b0;
            r_emitted <= '0;
            r_prev_r  <= '0;
            r_prev_i  <= '0;
        end else begin
            r_state <= n_state;
            // start a request
            if (req_fire) begin
                r_emitted <= emit_start;
                r_fresh   <= (emit_start == '0);
                r_found   <= 1'b0;
                r_cnt     <= 2'd0;
                r_issue   <= (emit_start < r_keep);
            end
            // issue one cell per cycle
            if (r_state == S_SCAN) begin
                r_b_vld <= r_issue;
                if (r_issue && last_cell) begin
                    r_issue <= 1'b0;
                end
                // fold the candidate into the running best
                if (r_b_vld && gt_prev) begin
                    if (r_cnt != 2'd2) begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                    if (lt_best) begin
                        r_found <= 1'b1;
                    end
                end
            end
            // commit the run state with the result
            if ((r_state == S_PUT) && out_free && r_found) begin
                r_prev_r  <= r_best_r;
                r_prev_i  <= r_best_i;
                r_emitted <= emit_inc[KW-1:0];
            end
        end
    end

    // Scan counters and datapath
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_col   <= '0;
            r_row   <= '0;
            r_idx   <= '0;
            r_rowsq <= '0;
        end else if ((r_state == S_SCAN) && r_issue) begin
            r_idx <= r_idx + IW'(1);
            if (r_col == w_eff - WW'(1)) begin
                r_col   <= '0;
                r_row   <= r_row + HW'(1);
                r_rowsq <= r_rowsq + R2W'({r_row, 1'b1});
            end else begin
                r_col <= r_col + WW'(1);
            end
        end
        // squared radius of the issued cell
        r_b_r2  <= R2W'(dx_sq) + r_rowsq;
        r_b_idx <= r_idx;
        // hold the best key seen so far
        if ((r_state == S_SCAN) && r_b_vld && gt_prev && lt_best) begin
            r_best_r <= r_b_r2;
            r_best_i <= r_b_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_PUT) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_PUT) && out_free) begin
            if (r_found) begin
                r_out.cell_index     <= r_best_i[rio_pkg::CELL_W-1:0];
                r_out.radius_squared <= r_best_r[rio_pkg::RAD_W-1:0];
                r_out.valid_res      <= 1'b1;
                r_out.last           <= (emit_inc >= {1'b0, r_keep}) || (r_cnt == 2'd1);
            end else begin
                r_out <= '0;
            end
        end
    end

    // Checks
    `RIO_ASSERT_SAME(a_empty_res_zero, i_clk, i_rst_n, o_res.valid && !o_res.data.valid_res, (o_res.data.cell_index == '0) && (o_res.data.radius_squared == '0) && !o_res.data.last)
    `RIO_ASSERT_SAME(a_scan_only_busy, i_clk, i_rst_n, r_issue || r_b_vld, r_state == S_SCAN)
    `RIO_ASSERT_NEXT(a_emit_single_step, i_clk, i_rst_n, 1'b1, (r_emitted == $past(r_emitted)) || (r_emitted == $past(r_emitted) + 1'b1) || (r_emitted == '0))

endmodule
